>>> rtl/cprc_pkg.sv
// Shared types, constants and digit-weight functions of the corner rank codec.
`timescale 1ns / 1ps

package cprc_pkg;

    // Request types.
    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Geometry of the corner state and of the cell chain.
    localparam int NUM_PIECES = 8;
    localparam int NUM_ORIENT = 7;
    localparam int NUM_TRITS  = 24;
    localparam int NUM_CELLS  = 24;

    // Code limits.
    localparam logic [26:0] EIGHT_FAC  = 27'd40320;
    localparam logic [26:0] POS_LIMIT  = 27'd88179840;
    localparam logic [38:0] PROT_LIMIT = 39'd282429536481;

    // One request as it travels down the chain. In encode mode pos and prot
    // accumulate the codes; in decode mode they hold the remainders still to
    // be split into digits, and signs, axes and trits collect the results.
    typedef struct packed {
        logic        mode;
        logic        bad;
        logic [26:0] pos;
        logic [38:0] prot;
        logic [23:0] signs;
        logic [13:0] axes;
        logic [47:0] trits;
        logic [7:0]  used;
    } cprc_item_t;

    // Corner number from the three sign bits of a piece.
    function automatic logic [2:0] sign_to_corner(input logic [2:0] s);
        logic [2:0] c;
        case (s)
            3'd0:    c = 3'd0;
            3'd1:    c = 3'd1;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd5;
            3'd4:    c = 3'd3;
            3'd5:    c = 3'd4;
            3'd6:    c = 3'd6;
            default: c = 3'd7;
        endcase
        return c;
    endfunction

    // Sign bits of a corner number.
    function automatic logic [2:0] corner_to_sign(input logic [2:0] c);
        logic [2:0] s;
        case (c)
            3'd0:    s = 3'd0;
            3'd1:    s = 3'd1;
            3'd2:    s = 3'd2;
            3'd3:    s = 3'd4;
            3'd4:    s = 3'd5;
            3'd5:    s = 3'd3;
            3'd6:    s = 3'd6;
            default: s = 3'd7;
        endcase
        return s;
    endfunction

    // Power of three, evaluated at elaboration for digit weights.
    function automatic logic [38:0] pow3(input int n);
        logic [38:0] acc;
        acc = 39'd1;
        for (int k = 0; k < n; k++) begin
            acc = 39'(acc * 39'd3);
        end
        return acc;
    endfunction

    // Factorial, evaluated at elaboration for permutation digit weights.
    function automatic logic [15:0] factorial(input int n);
        logic [15:0] acc;
        acc = 16'd1;
        for (int k = 2; k <= n; k++) begin
            acc = 16'(acc * 16'(k));
        end
        return acc;
    endfunction

endpackage

>>> rtl/cprc_trit_step.sv
// Combinational step of one protrusion trit: pack in encode, extract in decode.
`timescale 1ns / 1ps

module cprc_trit_step #(
    parameter int INDEX = 0
) (
    input  cprc_pkg::cprc_item_t item_in,
    output cprc_pkg::cprc_item_t item_out
);

    // Weight of this trit in the packed code; trit 0 is most significant.
    localparam logic [38:0] WEIGHT  = cprc_pkg::pow3(cprc_pkg::NUM_TRITS - 1 - INDEX);
    localparam logic [38:0] WEIGHT2 = {WEIGHT[37:0], 1'b0};

    logic [1:0]  trit;
    logic [38:0] tripled;

    // Encode shifts the accumulator by one base-3 digit; decode peels the
    // digit off the remainder by comparing against its weight.
    always_comb
    begin
        item_out = item_in;
        trit     = item_in.trits[2*INDEX +: 2];
        tripled  = {item_in.prot[37:0], 1'b0} + item_in.prot;
        if (item_in.mode == cprc_pkg::REQ_ENCODE)
        begin
            item_out.prot = tripled + {37'd0, trit};
            if (trit == 2'd3)
            begin
                item_out.bad = 1'b1;
            end
        end
        else
        begin
            if (item_in.prot >= WEIGHT2)
            begin
                item_out.prot               = item_in.prot - WEIGHT2;
                item_out.trits[2*INDEX +: 2] = 2'd2;
            end
            else if (item_in.prot >= WEIGHT)
            begin
                item_out.prot               = item_in.prot - WEIGHT;
                item_out.trits[2*INDEX +: 2] = 2'd1;
            end
            else
            begin
                item_out.trits[2*INDEX +: 2] = 2'd0;
            end
        end
    end

endmodule

>>> rtl/cprc_pos_step.sv
// Combinational step of one position digit: an orientation digit or a Lehmer digit.
`timescale 1ns / 1ps

module cprc_pos_step #(
    parameter int INDEX = 0
) (
    input  cprc_pkg::cprc_item_t item_in,
    output cprc_pkg::cprc_item_t item_out
);

    generate
        if (INDEX < cprc_pkg::NUM_ORIENT)
        begin : g_orient
            // Orientation digit of piece INDEX, weight 40320 * 3^(6-INDEX).
            localparam logic [26:0] OWT  = 27'(cprc_pkg::EIGHT_FAC *
                                              cprc_pkg::pow3(cprc_pkg::NUM_ORIENT - 1 - INDEX));
            localparam logic [26:0] OWT2 = {OWT[25:0], 1'b0};

            logic [1:0] axis;

            always_comb
            begin
                item_out = item_in;
                axis     = item_in.axes[2*INDEX +: 2];
                if (item_in.mode == cprc_pkg::REQ_ENCODE)
                begin
                    item_out.pos = item_in.pos + 27'(OWT * {25'd0, axis});
                    if (axis == 2'd3)
                    begin
                        item_out.bad = 1'b1;
                    end
                end
                else
                begin
                    if (item_in.pos >= OWT2)
                    begin
                        item_out.pos                = item_in.pos - OWT2;
                        item_out.axes[2*INDEX +: 2] = 2'd2;
                    end
                    else if (item_in.pos >= OWT)
                    begin
                        item_out.pos                = item_in.pos - OWT;
                        item_out.axes[2*INDEX +: 2] = 2'd1;
                    end
                    else
                    begin
                        item_out.axes[2*INDEX +: 2] = 2'd0;
                    end
                end
            end
        end
        else
        begin : g_perm
            // Lehmer digit of one piece, weight (7-piece)!.
            localparam int          PIECE = INDEX - cprc_pkg::NUM_ORIENT;
            localparam logic [15:0] FACT  = cprc_pkg::factorial(cprc_pkg::NUM_PIECES - 1 - PIECE);

            logic [2:0] corner;
            logic [2:0] below;
            logic [2:0] digit;
            logic [2:0] seen;
            logic       hit;

            always_comb
            begin
                item_out = item_in;
                corner   = cprc_pkg::sign_to_corner(item_in.signs[3*PIECE +: 3]);
                below    = 3'd0;
                digit    = 3'd0;
                seen     = 3'd0;
                hit      = 1'b0;
                if (item_in.mode == cprc_pkg::REQ_ENCODE)
                begin
                    // Count the free corners below this piece's corner.
                    for (int j = 0; j < cprc_pkg::NUM_PIECES; j++)
                    begin
                        if ((j < int'(corner)) && !item_in.used[j])
                        begin
                            below = below + 3'd1;
                        end
                    end
                    item_out.pos          = item_in.pos + 27'(FACT) * 27'(below);
                    item_out.used[corner] = 1'b1;
                end
                else
                begin
                    // Digit value from the remainder, one compare per candidate digit value.
                    for (int k = 1; k < cprc_pkg::NUM_PIECES - PIECE; k++)
                    begin
                        if (item_in.pos >= 27'(k) * 27'(FACT))
                        begin
                            digit = digit + 3'd1;
                        end
                    end
                    item_out.pos = item_in.pos - 27'(FACT) * 27'(digit);
                    // The digit picks the n-th corner not yet taken.
                    for (int j = 0; j < cprc_pkg::NUM_PIECES; j++)
                    begin
                        if (!item_in.used[j])
                        begin
                            if ((seen == digit) && !hit)
                            begin
                                hit = 1'b1;
                                item_out.used[j] = 1'b1;
                                item_out.signs[3*PIECE +: 3] = cprc_pkg::corner_to_sign(3'(j));
                            end
                            seen = seen + 3'd1;
                        end
                    end
                end
            end
        end
    endgenerate

endmodule

>>> rtl/cprc_cell.sv
// One cell of the codec chain: digit steps plus a registered stage with handshake.
`timescale 1ns / 1ps

module cprc_cell #(
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  cprc_pkg::cprc_item_t up_item,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output cprc_pkg::cprc_item_t dn_item
);

    cprc_pkg::cprc_item_t mid_item;
    cprc_pkg::cprc_item_t item_next;
    cprc_pkg::cprc_item_t item_reg;
    logic                 valid_reg;
    logic                 valid_next;

    // Position digit, present in the first fifteen cells only.
    generate
        if (INDEX < cprc_pkg::NUM_ORIENT + cprc_pkg::NUM_PIECES)
        begin : g_pos
            cprc_pos_step #(.INDEX(INDEX)) u_pos (
                .item_in  (up_item),
                .item_out (mid_item)
            );
        end
        else
        begin : g_no_pos
            assign mid_item = up_item;
        end
    endgenerate

    // Protrusion trit, one per cell.
    cprc_trit_step #(.INDEX(INDEX)) u_trit (
        .item_in  (mid_item),
        .item_out (item_next)
    );

    // The stage takes a new request when empty or when its own is leaving.
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

>>> rtl/corner_permutation_rank_codec_unit.sv
// Top level of the corner permutation rank codec: entry checks, cell chain, result format.
`timescale 1ns / 1ps

// Encodes or decodes one eight-corner state per request: the Lehmer rank of
// the corner permutation with seven base-3 orientation digits above it, and
// the 24 protrusion trits packed in base 3. Requests flow through a chain of
// 24 registered cells, each handling one protrusion trit and, in the first
// fifteen, one orientation or permutation digit, and a new request is taken
// every cycle while the result side keeps up. Each cell stalls only when it
// holds a request that cannot move, so empty stages are filled even while a
// result waits. Duplicate corners, an orientation axis of 3, a trit of 3 or
// an out-of-range code give status 1 with all data fields zero.
module corner_permutation_rank_codec_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        req_type,
    input  logic [23:0] corner_signs_in,
    input  logic [13:0] orient_axes_in,
    input  logic [47:0] protrude_trits_in,
    input  logic [26:0] position_code_in,
    input  logic [38:0] protrude_code_in,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [26:0] position_code_out,
    output logic [38:0] protrude_code_out,
    output logic [23:0] corner_signs_out,
    output logic [13:0] orient_axes_out,
    output logic [47:0] protrude_trits_out,
    output logic        status
);

    logic                 valid_chain [cprc_pkg::NUM_CELLS+1];
    logic                 ready_chain [cprc_pkg::NUM_CELLS+1];
    cprc_pkg::cprc_item_t item_chain  [cprc_pkg::NUM_CELLS+1];
    cprc_pkg::cprc_item_t entry_item;
    cprc_pkg::cprc_item_t last_item;
    logic [7:0]           occupied;

    // Entry: load the request fields and run the whole-request checks.
    always_comb
    begin
        occupied = 8'd0;
        for (int p = 0; p < cprc_pkg::NUM_PIECES; p++)
        begin
            occupied[cprc_pkg::sign_to_corner(corner_signs_in[3*p +: 3])] = 1'b1;
        end
        entry_item      = '0;
        entry_item.mode = req_type;
        if (req_type == cprc_pkg::REQ_ENCODE)
        begin
            entry_item.signs = corner_signs_in;
            entry_item.axes  = orient_axes_in;
            entry_item.trits = protrude_trits_in;
            entry_item.bad   = (occupied != 8'hFF);
        end
        else
        begin
            entry_item.pos  = position_code_in;
            entry_item.prot = protrude_code_in;
            entry_item.bad  = (position_code_in >= cprc_pkg::POS_LIMIT) ||
                              (protrude_code_in >= cprc_pkg::PROT_LIMIT);
        end
    end

    assign valid_chain[0] = req_valid;
    assign item_chain[0]  = entry_item;
    assign req_ready      = ready_chain[0];

    // The chain of digit cells.
    generate
        for (genvar i = 0; i < cprc_pkg::NUM_CELLS; i++)
        begin : g_cell
            cprc_cell #(.INDEX(i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (valid_chain[i]),
                .up_ready (ready_chain[i]),
                .up_item  (item_chain[i]),
                .dn_valid (valid_chain[i+1]),
                .dn_ready (ready_chain[i+1]),
                .dn_item  (item_chain[i+1])
            );
        end
    endgenerate

    assign rsp_valid                        = valid_chain[cprc_pkg::NUM_CELLS];
    assign ready_chain[cprc_pkg::NUM_CELLS] = rsp_ready;
    assign last_item                        = item_chain[cprc_pkg::NUM_CELLS];

    // Result format: only the fields of the request's mode, all zero if invalid.
    always_comb
    begin
        position_code_out  = 27'd0;
        protrude_code_out  = 39'd0;
        corner_signs_out   = 24'd0;
        orient_axes_out    = 14'd0;
        protrude_trits_out = 48'd0;
        status             = last_item.bad;
        if (!last_item.bad)
        begin
            if (last_item.mode == cprc_pkg::REQ_ENCODE)
            begin
                position_code_out = last_item.pos;
                protrude_code_out = last_item.prot;
            end
            else
            begin
                corner_signs_out   = last_item.signs;
                orient_axes_out    = last_item.axes;
                protrude_trits_out = last_item.trits;
            end
        end
    end

endmodule

>>> sim/corner_permutation_rank_codec_unit_tb.sv
// Self-checking testbench for the corner permutation rank codec with random handshake idling.
`timescale 1ns / 1ps

module corner_permutation_rank_codec_unit_tb;

    localparam int IDLE_MAX     = 12;
    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 48;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    // Corner number for each sign pattern, and sign pattern for each corner,
    // packed three bits per entry with entry 0 in the low bits.
    localparam logic [23:0] CORNER_OF_SIGN = {3'd7, 3'd6, 3'd4, 3'd3, 3'd5, 3'd2, 3'd1, 3'd0};
    localparam logic [23:0] SIGN_OF_CORNER = {3'd7, 3'd6, 3'd3, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0};

    // Piece i on corner i, and piece i on corner 7-i.
    localparam logic [23:0] SIGNS_IDENT = SIGN_OF_CORNER;
    localparam logic [23:0] SIGNS_REV   = {3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd7};
    localparam logic [23:0] SIGNS_DUP7  = {3'd0, 3'd6, 3'd3, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0};

    localparam logic [13:0] AXES_ALL2   = 14'h2AAA;
    localparam logic [47:0] TRITS_ALL2  = 48'hAAAA_AAAA_AAAA;
    localparam logic [26:0] POS_MAX     = 27'd88179839;
    localparam logic [38:0] PROT_MAX    = 39'd282429536480;

    typedef struct packed {
        logic        kind;
        logic [23:0] signs;
        logic [13:0] axes;
        logic [47:0] trits;
        logic [26:0] pos;
        logic [38:0] prot;
    } codec_req_t;

    typedef struct packed {
        logic [26:0] pos;
        logic [38:0] prot;
        logic [23:0] signs;
        logic [13:0] axes;
        logic [47:0] trits;
        logic        status;
    } codec_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic        req_type;
    logic [23:0] corner_signs_in;
    logic [13:0] orient_axes_in;
    logic [47:0] protrude_trits_in;
    logic [26:0] position_code_in;
    logic [38:0] protrude_code_in;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [26:0] position_code_out;
    logic [38:0] protrude_code_out;
    logic [23:0] corner_signs_out;
    logic [13:0] orient_axes_out;
    logic [47:0] protrude_trits_out;
    logic        status;

    codec_rsp_t pending_results[$];
    codec_req_t dir_reqs[$];
    bit         dir_literal[$];
    codec_rsp_t dir_wants[$];

    int mismatches   = 0;
    int results_seen = 0;
    int invalid_seen = 0;
    int encode_sent  = 0;
    int decode_sent  = 0;
    int idle_cycles  = 0;
    int sender_calm  = 0;
    int receiver_calm = 0;

    corner_permutation_rank_codec_unit i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_ready          (req_ready),
        .req_type           (req_type),
        .corner_signs_in    (corner_signs_in),
        .orient_axes_in     (orient_axes_in),
        .protrude_trits_in  (protrude_trits_in),
        .position_code_in   (position_code_in),
        .protrude_code_in   (protrude_code_in),
        .rsp_valid          (rsp_valid),
        .rsp_ready          (rsp_ready),
        .position_code_out  (position_code_out),
        .protrude_code_out  (protrude_code_out),
        .corner_signs_out   (corner_signs_out),
        .orient_axes_out    (orient_axes_out),
        .protrude_trits_out (protrude_trits_out),
        .status             (status)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Expected codec result for one request.
    function automatic codec_rsp_t predict_codec_result(input codec_req_t r);
        codec_rsp_t      res;
        logic [7:0]      taken;
        logic [2:0]      c;
        logic [1:0]      digit2;
        longint unsigned rank;
        longint unsigned orient;
        longint unsigned prot;
        longint unsigned code;
        longint unsigned rem;
        longint unsigned place;
        longint unsigned dig;
        int              i;
        int              j;
        int              below;
        bit              bad;
        res    = '0;
        bad    = 1'b0;
        taken  = '0;
        rank   = 0;
        orient = 0;
        prot   = 0;
        if (r.kind == cprc_pkg::REQ_ENCODE)
        begin
            // Lehmer digits and orientation digits, piece 0 most significant.
            for (i = 0; i < cprc_pkg::NUM_PIECES; i++)
            begin
                c = CORNER_OF_SIGN[3 * int'(r.signs[3 * i +: 3]) +: 3];
                if (taken[c])
                    bad = 1'b1;
                if (i < cprc_pkg::NUM_PIECES - 1)
                begin
                    below = 0;
                    for (j = 0; j < int'(c); j++)
                        if (!taken[j])
                            below++;
                    rank   = rank * (cprc_pkg::NUM_PIECES - i) + below;
                    digit2 = r.axes[2 * i +: 2];
                    if (digit2 == 2'd3)
                        bad = 1'b1;
                    orient = orient * 3 + digit2;
                end
                taken[c] = 1'b1;
            end
            // Protrusion trits, component 0 most significant.
            for (i = 0; i < cprc_pkg::NUM_TRITS; i++)
            begin
                digit2 = r.trits[2 * i +: 2];
                if (digit2 == 2'd3)
                    bad = 1'b1;
                prot = prot * 3 + digit2;
            end
            if (!bad)
            begin
                res.pos  = 27'(rank + orient * cprc_pkg::EIGHT_FAC);
                res.prot = 39'(prot);
            end
        end
        else
        begin
            code = r.pos;
            prot = r.prot;
            if (code >= cprc_pkg::POS_LIMIT || prot >= cprc_pkg::PROT_LIMIT)
                bad = 1'b1;
            else
            begin
                orient = code / cprc_pkg::EIGHT_FAC;
                rem    = code % cprc_pkg::EIGHT_FAC;
                for (i = cprc_pkg::NUM_PIECES - 2; i >= 0; i--)
                begin
                    res.axes[2 * i +: 2] = 2'(orient % 3);
                    orient = orient / 3;
                end
                // Each mixed-radix digit selects among the corners still free.
                place = cprc_pkg::EIGHT_FAC;
                for (i = 0; i < cprc_pkg::NUM_PIECES; i++)
                begin
                    place = place / (cprc_pkg::NUM_PIECES - i);
                    dig   = rem / place;
                    rem   = rem % place;
                    for (j = 0; j < cprc_pkg::NUM_PIECES; j++)
                    begin
                        if (!taken[j])
                        begin
                            if (dig == 0)
                            begin
                                taken[j] = 1'b1;
                                res.signs[3 * i +: 3] = SIGN_OF_CORNER[3 * j +: 3];
                                break;
                            end
                            dig--;
                        end
                    end
                end
                for (i = cprc_pkg::NUM_TRITS - 1; i >= 0; i--)
                begin
                    res.trits[2 * i +: 2] = 2'(prot % 3);
                    prot = prot / 3;
                end
            end
        end
        res.status = bad;
        return res;
    endfunction

    function automatic codec_req_t mk_req(input logic kind, input logic [23:0] signs,
                                          input logic [13:0] axes, input logic [47:0] trits,
                                          input logic [26:0] pos, input logic [38:0] prot);
        codec_req_t r;
        r = '{kind: kind, signs: signs, axes: axes, trits: trits, pos: pos, prot: prot};
        return r;
    endfunction

    function automatic codec_rsp_t mk_rsp(input logic [26:0] pos, input logic [38:0] prot,
                                          input logic [23:0] signs, input logic [13:0] axes,
                                          input logic [47:0] trits, input logic st);
        codec_rsp_t w;
        w = '{pos: pos, prot: prot, signs: signs, axes: axes, trits: trits, status: st};
        return w;
    endfunction

    task automatic add_row(input codec_req_t r, input bit lit, input codec_rsp_t w);
        dir_reqs.push_back(r);
        dir_literal.push_back(lit);
        dir_wants.push_back(w);
    endtask

    // Idle cycles before the next item, with occasional stretches of none.
    function automatic int draw_wait(ref int calm_left);
        int n;
        if (calm_left > 0)
        begin
            calm_left--;
            n = 0;
        end
        else
        begin
            n = $urandom_range(0, IDLE_MAX);
            if ($urandom_range(0, 39) == 0)
                calm_left = $urandom_range(10, 40);
        end
        return n;
    endfunction

    // Random request: mostly well-formed states and codes, some broken, some noise.
    function automatic codec_req_t random_request();
        codec_req_t r;
        logic [2:0] perm [8];
        logic [2:0] t;
        int         sel;
        int         k;
        int         pick;
        int         other;
        r.kind  = 1'($urandom);
        r.signs = 24'($urandom);
        r.axes  = 14'($urandom);
        r.trits = 48'({$urandom, $urandom});
        r.pos   = 27'($urandom);
        r.prot  = 39'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 45)
        begin
            r.kind = cprc_pkg::REQ_ENCODE;
            for (k = 0; k < cprc_pkg::NUM_PIECES; k++)
                perm[k] = 3'(k);
            for (k = cprc_pkg::NUM_PIECES - 1; k > 0; k--)
            begin
                pick       = $urandom_range(0, k);
                t          = perm[k];
                perm[k]    = perm[pick];
                perm[pick] = t;
            end
            for (k = 0; k < cprc_pkg::NUM_PIECES; k++)
                r.signs[3 * k +: 3] = SIGN_OF_CORNER[3 * int'(perm[k]) +: 3];
            for (k = 0; k < cprc_pkg::NUM_ORIENT; k++)
                r.axes[2 * k +: 2] = 2'($urandom_range(0, 2));
            for (k = 0; k < cprc_pkg::NUM_TRITS; k++)
                r.trits[2 * k +: 2] = 2'($urandom_range(0, 2));
            if (sel < 8)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        pick  = $urandom_range(0, cprc_pkg::NUM_PIECES - 1);
                        other = (pick + $urandom_range(1, cprc_pkg::NUM_PIECES - 1)) %
                                cprc_pkg::NUM_PIECES;
                        r.signs[3 * other +: 3] = r.signs[3 * pick +: 3];
                    end
                    1:
                    begin
                        r.axes[2 * $urandom_range(0, cprc_pkg::NUM_ORIENT - 1) +: 2] = 2'd3;
                    end
                    default:
                    begin
                        r.trits[2 * $urandom_range(0, cprc_pkg::NUM_TRITS - 1) +: 2] = 2'd3;
                    end
                endcase
            end
        end
        else if (sel < 85)
        begin
            r.kind = cprc_pkg::REQ_DECODE;
            r.pos  = 27'($urandom_range(0, cprc_pkg::POS_LIMIT - 1));
            r.prot = 39'({$urandom, $urandom} % cprc_pkg::PROT_LIMIT);
            if (sel < 53)
            begin
                case ($urandom_range(0, 3))
                    0:       r.pos  = 27'($urandom_range(cprc_pkg::POS_LIMIT, 27'h7FFFFFF));
                    1:
                    begin
                        r.prot = 39'(cprc_pkg::PROT_LIMIT +
                                     ({$urandom, $urandom} %
                                      ((64'd1 << 39) - cprc_pkg::PROT_LIMIT)));
                    end
                    2:       r.pos  = cprc_pkg::POS_LIMIT - 27'd1;
                    default: r.prot = cprc_pkg::PROT_LIMIT - 39'd1;
                endcase
            end
        end
        return r;
    endfunction

    // Send one request after a random gap and record what it should produce.
    task automatic send_request(input codec_req_t r, input codec_rsp_t want);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type          <= r.kind;
        corner_signs_in   <= r.signs;
        orient_axes_in    <= r.axes;
        protrude_trits_in <= r.trits;
        position_code_in  <= r.pos;
        protrude_code_in  <= r.prot;
        req_valid         <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_results.push_back(want);
        if (r.kind == cprc_pkg::REQ_ENCODE)
            encode_sent++;
        else
            decode_sent++;
    endtask

    task automatic note_mismatch(input string what, input codec_rsp_t want,
                                 input codec_rsp_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("%s: expected pos=%h prot=%h signs=%h axes=%h trits=%h st=%b",
                     what, want.pos, want.prot, want.signs, want.axes, want.trits,
                     want.status);
            $display("    actual pos=%h prot=%h signs=%h axes=%h trits=%h st=%b",
                     got.pos, got.prot, got.signs, got.axes, got.trits, got.status);
        end
    endtask

    // Main sequence: reset, directed table, random requests, drain.
    initial
    begin
        codec_req_t r;
        codec_rsp_t none;
        codec_rsp_t rejected;
        none     = '0;
        rejected = mk_rsp('0, '0, '0, '0, '0, 1'b1);

        // Directed table; literal rows carry results that follow directly from the codes.
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_IDENT, '0, '0, '0, '0), 1'b1, none);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_REV, AXES_ALL2, TRITS_ALL2, '0, '0),
                1'b1, mk_rsp(POS_MAX, PROT_MAX, '0, '0, '0, 1'b0));
        add_row(mk_req(cprc_pkg::REQ_ENCODE, '0, '0, '0, '0, '0), 1'b1, rejected);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, '1, '1, '1, '1, '1), 1'b1, rejected);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_IDENT, 14'h0003, '0, '0, '0), 1'b1,
                rejected);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_IDENT, 14'h3000, '0, '0, '0), 1'b1,
                rejected);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_IDENT, '0, 48'h3, '0, '0), 1'b1,
                rejected);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_IDENT, '0, 48'hC000_0000_0000, '0, '0),
                1'b1, rejected);
        // Only the last piece repeats a corner.
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_DUP7, '0, '0, '0, '0), 1'b1, rejected);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, '0, '0), 1'b1,
                mk_rsp('0, '0, SIGNS_IDENT, '0, '0, 1'b0));
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, POS_MAX, PROT_MAX), 1'b1,
                mk_rsp('0, '0, SIGNS_REV, AXES_ALL2, TRITS_ALL2, 1'b0));
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, cprc_pkg::POS_LIMIT, '0), 1'b1,
                rejected);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, '0, cprc_pkg::PROT_LIMIT), 1'b1,
                rejected);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '1, '1, '1, '1, '1), 1'b1, rejected);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, cprc_pkg::EIGHT_FAC, '0), 1'b0,
                none);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, cprc_pkg::EIGHT_FAC - 27'd1, 39'd1),
                1'b0, none);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '0, '0, '0, 27'd12345678, 39'd98765432101),
                1'b0, none);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, {3'd7, 3'd6, 3'd3, 3'd5, 3'd4, 3'd2, 3'd0, 3'd1},
                       14'h1555, 48'h5555_5555_5555, '0, '0), 1'b0, none);
        add_row(mk_req(cprc_pkg::REQ_ENCODE, SIGNS_REV, 14'h0AAA, 48'h1234_5654_1A2A, '1, '1),
                1'b0, none);
        add_row(mk_req(cprc_pkg::REQ_DECODE, '1, '1, '1, '0, '0), 1'b0, none);

        rst_n             <= 1'b0;
        req_valid         <= 1'b0;
        req_type          <= cprc_pkg::REQ_ENCODE;
        corner_signs_in   <= '0;
        orient_axes_in    <= '0;
        protrude_trits_in <= '0;
        position_code_in  <= '0;
        protrude_code_in  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < dir_reqs.size(); k++)
            send_request(dir_reqs[k],
                         dir_literal[k] ? dir_wants[k] : predict_codec_result(dir_reqs[k]));

        // Let the pipeline run dry before the random part.
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                req_valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            r = random_request();
            send_request(r, predict_codec_result(r));
        end

        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d encode and %0d decode requests, %0d from the directed table.",
                 encode_sent, decode_sent, dir_reqs.size());
        $display("Checked %0d results, %0d flagged invalid, %0d mismatches.",
                 results_seen, invalid_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, then compare each result with the oldest expectation.
    initial
    begin
        codec_rsp_t got;
        codec_rsp_t want;
        int         stall;
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(receiver_calm);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            got = mk_rsp(position_code_out, protrude_code_out, corner_signs_out,
                         orient_axes_out, protrude_trits_out, status);
            results_seen++;
            if (got.status == 1'b1)
                invalid_seen++;
            if (pending_results.size() == 0)
                note_mismatch("result with no request pending", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.pos !== want.pos || got.prot !== want.prot ||
                    got.signs !== want.signs || got.axes !== want.axes ||
                    got.trits !== want.trits || got.status !== want.status)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // Watchdog: cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
                     STALL_LIMIT, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
